// ===== hdl/thermometer_scratchpad_decoder_defines.svh =====
// Assertion helpers, clocked on clk with rst masking.
`ifndef THERMOMETER_SCRATCHPAD_DECODER_DEFINES_SVH
`define THERMOMETER_SCRATCHPAD_DECODER_DEFINES_SVH

// Same-cycle implication.
`define TSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tsd_pkg.sv =====
`timescale 1ns / 1ps

package tsd_pkg;

  localparam int SCRATCHPAD_BYTES = 9;
  localparam int POS_W = $clog2(SCRATCHPAD_BYTES);

  localparam logic [POS_W-1:0] POS_TEMP_LOW  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TEMP_HIGH = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CONFIG    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(SCRATCHPAD_BYTES - 1);

  localparam logic [7:0]         CRC_POLY     = 8'h8C;
  localparam logic signed [11:0] REJECT_VALUE = -12'sd999;

  typedef enum logic [1:0] {
    RES_9BIT  = 2'd0,
    RES_10BIT = 2'd1,
    RES_11BIT = 2'd2,
    RES_12BIT = 2'd3
  } res_code_t;

  typedef struct packed {
    logic signed [11:0] temperature_c;
    logic               data_ok;
    logic signed [15:0] raw_reading;
    logic [1:0]         resolution_code;
    logic [7:0]         computed_crc;
  } result_t;

  // Reflected CRC-8, LSB first, one byte.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] b);
    logic [7:0] c;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] res_mask(input res_code_t code);
    logic [15:0] m;
    case (code)
      RES_9BIT:  m = 16'hFFF8;
      RES_10BIT: m = 16'hFFFC;
      RES_11BIT: m = 16'hFFFE;
      RES_12BIT: m = 16'hFFFF;
      default:   m = 16'hFFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/tsd_channels.sv =====
`timescale 1ns / 1ps

interface tsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tsd_result_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] temperature_c;
  logic               data_ok;
  logic signed [15:0] raw_reading;
  logic [1:0]         resolution_code;
  logic [7:0]         computed_crc;
  modport source (output valid, output temperature_c, output data_ok, output raw_reading,
                  output resolution_code, output computed_crc, input ready);
  modport sink   (input valid, input temperature_c, input data_ok, input raw_reading,
                  input resolution_code, input computed_crc, output ready);
endinterface

interface tsd_cfg_if;
  logic valid;
  logic ready;
  logic crc_check_enable;
  modport source (output valid, output crc_check_enable, input ready);
  modport sink   (input valid, input crc_check_enable, output ready);
endinterface

// ===== hdl/thermometer_scratchpad_decoder.sv =====
`timescale 1ns / 1ps
// channel | dir | word
// data    | in  | data_byte: one scratchpad byte, bus order
// result  | out | temperature_c, data_ok, raw_reading, resolution_code, computed_crc
// cfg     | in  | crc_check_enable
// One byte per cycle while ready; a frame's result registers as its last byte is taken.
// The output register holds a result until taken; only a last byte waits on it.
// rst (synchronous) clears the byte position, CRC, check enable and result valid.
// cfg is always ready.

`include "thermometer_scratchpad_decoder_defines.svh"

module thermometer_scratchpad_decoder (
  input logic         clk,
  input logic         rst,
  tsd_byte_if.sink    data,
  tsd_result_if.source result,
  tsd_cfg_if.sink     cfg
);

  logic [tsd_pkg::POS_W-1:0] byte_position;
  logic [7:0]                crc_register;
  logic [7:0]                temp_low_byte;
  logic [7:0]                temp_high_byte;
  logic [7:0]                config_byte;
  logic                      crc_check_enable;
  logic                      out_valid;
  tsd_pkg::result_t          out_word;
  tsd_pkg::result_t          out_word_next;

  logic                      at_last;
  logic                      in_fire;
  tsd_pkg::res_code_t        res;
  logic [15:0]               pattern;
  logic signed [11:0]        whole;
  logic                      ok;

  assign at_last    = (byte_position == tsd_pkg::POS_LAST);
  assign data.ready = !at_last || !out_valid || result.ready;
  assign in_fire    = data.valid && data.ready;
  assign cfg.ready  = 1'b1;

  always_comb begin
    res     = tsd_pkg::res_code_t'(config_byte[6:5]);
    pattern = {temp_high_byte, temp_low_byte} & tsd_pkg::res_mask(res);
    whole   = $signed(pattern[15:4]) + $signed({11'd0, pattern[15] && (|pattern[3:0])});
    ok      = !(crc_check_enable && (data.data_byte != crc_register));
    out_word_next.temperature_c   = ok ? whole : tsd_pkg::REJECT_VALUE;
    out_word_next.data_ok         = ok;
    out_word_next.raw_reading     = $signed(pattern);
    out_word_next.resolution_code = res;
    out_word_next.computed_crc    = crc_register;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      crc_register     <= '0;
      crc_check_enable <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        crc_check_enable <= cfg.crc_check_enable;
      end
      if (in_fire && at_last) begin
        out_valid     <= 1'b1;
        byte_position <= '0;
        crc_register  <= '0;
      end else begin
        if (result.ready) begin
          out_valid <= 1'b0;
        end
        if (in_fire) begin
          byte_position <= byte_position + tsd_pkg::POS_W'(1);
          crc_register  <= tsd_pkg::crc8_update(crc_register, data.data_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      case (byte_position)
        tsd_pkg::POS_TEMP_LOW:  temp_low_byte  <= data.data_byte;
        tsd_pkg::POS_TEMP_HIGH: temp_high_byte <= data.data_byte;
        tsd_pkg::POS_CONFIG:    config_byte    <= data.data_byte;
        default: ;
      endcase
      if (at_last) begin
        out_word <= out_word_next;
      end
    end
  end

  assign result.valid           = out_valid;
  assign result.temperature_c   = out_word.temperature_c;
  assign result.data_ok         = out_word.data_ok;
  assign result.raw_reading     = out_word.raw_reading;
  assign result.resolution_code = out_word.resolution_code;
  assign result.computed_crc    = out_word.computed_crc;

  `TSD_ASSERT_NOW(a_pos_range, 1'b1, byte_position <= tsd_pkg::POS_LAST, "position overrun")
  `TSD_ASSERT_NOW(a_valid_src, $rose(out_valid), $past(in_fire && at_last), "stray result")
  `TSD_ASSERT_NEXT(a_frame_restart, in_fire && at_last, byte_position == '0 && crc_register == '0, "frame not restarted")
  `TSD_ASSERT_NOW(a_reject_value, out_valid && !out_word.data_ok, out_word.temperature_c == tsd_pkg::REJECT_VALUE, "reject value")
  `TSD_ASSERT_NEXT(a_check_off_ok, in_fire && at_last && !crc_check_enable, out_word.data_ok, "check disabled but rejected")

endmodule
